// ----- design/cfc_pkg.sv -----
// Shared types, constants and the CRC-8 step for the CRSF frame checker.
// No dependencies; the datapath, controller, top level and checker import it.
package cfc_pkg;

    localparam int CFC_MAX_FRAME_BYTES = 64;
    localparam int CFC_CMP_W           = 8;
    localparam logic [7:0] CFC_CRC_POLY = 8'hD5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

    localparam logic [7:0] CFG_SYNC_RESET = 8'd200;
    localparam logic [5:0] CFG_MIN_RESET  = 6'd2;
    localparam logic [5:0] CFG_MAX_RESET  = 6'd62;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_SIZE = 3'd1,
        ST_SYNC = 3'd2,
        ST_LEN  = 3'd3,
        ST_CRC  = 3'd4
    } cfc_status_t;

    // controller -> datapath
    typedef struct packed {
        logic write_byte;   // store and count the incoming item
        logic close_burst;  // judge the burst, clear count and CRC
        logic load_single;  // load the one-result answer into the output register
        logic start_read;   // read the first payload byte
        logic load_byte;    // load a payload result, read the next byte if any
    } cfc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic single_result; // error or empty payload
        logic last_byte;     // RAM output holds the final payload byte
    } cfc_stat_t;

    // one byte through the MSB-first CRC-8
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CFC_CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ----- design/cfc_rx_if.sv -----
// Input channel of the CRSF frame checker: one link byte per item.
// Stands alone; no package needed.
interface cfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

// ----- design/cfc_res_if.sv -----
// Result channel of the CRSF frame checker: one result item per transfer.
// Stands alone; no package needed.
interface cfc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [5:0] frame_len;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output status, output frame_type, output frame_len,
                    output payload_byte, output byte_valid, output last, input ready);
    modport sink   (input valid, input status, input frame_type, input frame_len,
                    input payload_byte, input byte_valid, input last, output ready);
endinterface

// ----- design/cfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/cfc_datapath.sv -----
// Datapath of the CRSF frame checker: config registers, byte count, CRC,
// header bytes, burst checks, frame store and output register.
// Depends on cfc_pkg and cfc_ram.
module cfc_datapath
    import cfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = CFC_MAX_FRAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [7:0]           rx_byte,
    input  cfc_cmd_t             cmd,
    output cfc_stat_t            stat,
    output logic [2:0]           status,
    output logic [7:0]           frame_type,
    output logic [5:0]           frame_len,
    output logic [7:0]           payload_byte,
    output logic                 byte_valid,
    output logic                 last
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CFC_CMP_W-1:0] MAX_N = CFC_CMP_W'(MAX_FRAME_BYTES);
    localparam logic [AW-1:0] FIRST_PAYLOAD = AW'(3);

    logic [7:0]    sync_reg;
    logic [5:0]    min_reg, max_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    byte0_reg, byte1_reg, byte2_reg;
    cfc_status_t   st_reg, st_next;
    logic [5:0]    len_reg;
    logic          single_reg;
    logic [AW-1:0] rd_addr_reg, rd_addr;
    logic          rd_en, ram_we;
    logic [7:0]    ram_q;

    logic [2:0]    status_reg;
    logic [7:0]    type_reg, pbyte_reg;
    logic [5:0]    length_reg;
    logic          bvalid_reg, last_reg;

    logic [CFC_CMP_W-1:0] idx8, n8, len8, min8, max8;
    logic [7:0]           len_sel;

    // --- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= CFG_SYNC_RESET;
            min_reg  <= CFG_MIN_RESET;
            max_reg  <= CFG_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_VALUE: sync_reg <= cfg_data;
                CFG_MIN_LENGTH: min_reg  <= cfg_data[5:0];
                CFG_MAX_LENGTH: max_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // --- burst size and checks, evaluated on the closing byte
    always_comb
    begin
        idx8    = CFC_CMP_W'(count_reg);
        n8      = (idx8 <= MAX_N) ? idx8 + 8'd1 : idx8;   // saturates at max + 1
        len_sel = (idx8 == 8'd1) ? rx_byte : byte1_reg;
        len8    = len_sel;
        min8    = CFC_CMP_W'(min_reg);
        max8    = CFC_CMP_W'(max_reg);

        if (n8 < min8 + 8'd2 || n8 > max8 + 8'd2 || n8 > MAX_N)
            st_next = ST_SIZE;
        else if (byte0_reg != sync_reg)
            st_next = ST_SYNC;
        else if (len8 != n8 - 8'd2 || len8 < min8 || len8 > max8 || len8 < 8'd2)
            st_next = ST_LEN;
        else if (crc_reg != rx_byte)     // crc_reg is the value before this byte
            st_next = ST_CRC;
        else
            st_next = ST_OK;

        count_next = count_reg;
        crc_next   = crc_reg;
        if (cmd.close_burst)
        begin
            count_next = '0;
            crc_next   = '0;
        end
        else if (cmd.write_byte)
        begin
            count_next = CW'(n8);
            if (idx8 >= 8'd2)
                crc_next = crc8_feed(crc_reg, rx_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // header bytes and verdict
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            if (idx8 == 8'd0) byte0_reg <= rx_byte;
            if (idx8 == 8'd1) byte1_reg <= rx_byte;
            if (idx8 == 8'd2) byte2_reg <= rx_byte;
        end
        if (cmd.close_burst)
        begin
            st_reg     <= st_next;
            len_reg    <= len_sel[5:0];
            single_reg <= (st_next != ST_OK) || (len8 == 8'd2);
        end
    end

    // --- frame store
    assign ram_we  = cmd.write_byte && (idx8 < MAX_N);
    assign rd_en   = cmd.start_read || (cmd.load_byte && !stat.last_byte);
    assign rd_addr = cmd.start_read ? FIRST_PAYLOAD : rd_addr_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_addr_reg <= rd_addr;
    end

    cfc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign stat.single_result = single_reg;
    assign stat.last_byte     = (CFC_CMP_W'(rd_addr_reg) == CFC_CMP_W'(len_reg));

    // --- output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_single)
        begin
            status_reg <= st_reg;
            type_reg   <= (st_reg == ST_OK) ? byte2_reg : 8'd0;
            length_reg <= (st_reg == ST_OK) ? len_reg : 6'd0;
            pbyte_reg  <= 8'd0;
            bvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            status_reg <= ST_OK;
            type_reg   <= byte2_reg;
            length_reg <= len_reg;
            pbyte_reg  <= ram_q;
            bvalid_reg <= 1'b1;
            last_reg   <= stat.last_byte;
        end
    end

    assign status       = status_reg;
    assign frame_type   = type_reg;
    assign frame_len    = length_reg;
    assign payload_byte = pbyte_reg;
    assign byte_valid   = bvalid_reg;
    assign last         = last_reg;

endmodule

// ----- design/cfc_ctrl.sv -----
// Controller of the CRSF frame checker: input handshake, result sequencing
// and the output register's valid flag. Depends on cfc_pkg.
module cfc_ctrl
    import cfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    input  logic      rx_burst_end,
    output logic      rx_ready,
    output logic      res_valid,
    input  logic      res_ready,
    output cfc_cmd_t  cmd,
    input  cfc_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_FETCH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free, load;

    assign out_free = !valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rx_ready       = 1'b1;
                cmd.write_byte = rx_valid;
                if (rx_valid && rx_burst_end)
                begin
                    cmd.close_burst = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.single_result)
                begin
                    if (out_free)
                    begin
                        cmd.load_single = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start_read = 1'b1;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (stat.last_byte)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign load = cmd.load_single || cmd.load_byte;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && res_ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign res_valid = valid_reg;

endmodule

// ----- design/crsf_frame_checker_top.sv -----
// CRSF frame checker, top level. Bytes are taken one per cycle while no
// verdict is being handled and no result run is being read out. An error or
// empty-frame result goes from the registered verdict to the output register
// once that is free; for a payload run the first byte is read from the store,
// then payload results follow one per cycle while the sink keeps up.
// Reset (rst_n, async, low): count, CRC, control and config registers reset.
module crsf_frame_checker_top
    import cfc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = CFC_MAX_FRAME_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    // byte items in, result items out
    cfc_rx_if.sink               rx,
    cfc_res_if.source            result
);

    // Operation:
    //  * Each accepted byte is written to the frame store at the current count
    //    if below the store size; bytes 0..2 also go to registers (sync,
    //    length, type), and from byte 2 on the CRC-8 (poly 0xD5, init 0) advances.
    //  * The count saturates one past the store size so oversize bursts are
    //    caught by the size check.
    //  * On the byte flagged as burst end the checks run combinationally:
    //    size, sync, length, then CRC against the byte itself. The verdict
    //    is registered and count/CRC are cleared, dropping the burst.
    //  * An error or an empty payload gives one result. Otherwise payload
    //    bytes 3..length are read from the store and sent as a run, one
    //    per cycle while the sink keeps up.
    //  * The output register lets a new burst begin while the final result
    //    of the previous run still waits.

    cfc_cmd_t  cmd;
    cfc_stat_t stat;

    cfc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx.valid),
        .rx_burst_end (rx.burst_end),
        .rx_ready     (rx.ready),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    cfc_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx.rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .status       (result.status),
        .frame_type   (result.frame_type),
        .frame_len    (result.frame_len),
        .payload_byte (result.payload_byte),
        .byte_valid   (result.byte_valid),
        .last         (result.last)
    );

endmodule

// ----- design/cfc_checker.sv -----
// Port-level assertions for the CRSF frame checker, bound to the top level.
// Depends on cfc_pkg and crsf_frame_checker_top.
module cfc_checker
    import cfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] status,
    input logic [5:0] frame_len,
    input logic [7:0] payload_byte,
    input logic       byte_valid,
    input logic       last
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(payload_byte) && $stable(last))
        else $error("result changed while stalled");

    // only payload results continue a run
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> status == ST_OK && byte_valid)
        else $error("non-final result is not a payload byte");

    // error results stand alone and empty
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> last && !byte_valid && frame_len == 6'd0)
        else $error("malformed error result");

    // no input taken in the middle of a run
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !rx_ready)
        else $error("input accepted during a result run");

    // a payload byte implies a frame with payload
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_valid |-> frame_len >= 6'd3)
        else $error("payload byte with too short a length");

endmodule

bind crsf_frame_checker_top cfc_checker u_cfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .status       (result.status),
    .frame_len    (result.frame_len),
    .payload_byte (result.payload_byte),
    .byte_valid   (result.byte_valid),
    .last         (result.last)
);
